// ===== hdl/hdsp_pkg.sv =====
// Shared types and constants for the hex-and-dot byte spec parser.
// No dependencies; used by hdsp_core and the top level.
`default_nettype none

package hdsp_pkg;

    // Default for the top-level MAX_CAPACITY parameter.
    localparam int unsigned MAX_CAPACITY_DEF = 4096;

    localparam int unsigned CFG_W   = 13;
    localparam int unsigned FIELD_W = 13;

    // buffer_capacity after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 13'h1000;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_BAD_HEX    = 4'd1,
        ERR_BAD_DOT    = 4'd2,
        ERR_DUP_DOT    = 4'd3,
        ERR_BAD_DIGIT  = 4'd4,
        ERR_LEAD_ZERO  = 4'd5,
        ERR_NO_COUNT   = 4'd6,
        ERR_TOO_SMALL  = 4'd7,
        ERR_INCOMPLETE = 4'd8
    } t_err_code;

    // Input request: mode 1 marks end of text.
    typedef struct packed {
        logic       mode;
        logic [7:0] character;
    } t_in_req;

    // One result record.
    typedef struct packed {
        logic               emit;
        logic [7:0]         out_byte;
        logic [FIELD_W-1:0] repeat_res;
        logic               done_res;
        logic [3:0]         error_code;
        logic [FIELD_W-1:0] total_length;
    } t_out_res;

endpackage

`default_nettype wire

// ===== hdl/hdsp_core.sv =====
// Parser state and combinational step logic for one character or end marker.
// Depends on hdsp_pkg.
`default_nettype none

module hdsp_core #(
    parameter int unsigned MAX_CAPACITY = hdsp_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire hdsp_pkg::t_in_req        i_req,
    input  wire logic [hdsp_pkg::CFG_W-1:0] i_cap,
    output hdsp_pkg::t_out_res            o_res,
    output logic                          o_res_valid
);

    // count saturates at MAX_CAPACITY + 1
    localparam int unsigned W  = $clog2(MAX_CAPACITY + 2);
    localparam int unsigned MW = W + 4;
    localparam int unsigned CW = (W > hdsp_pkg::CFG_W) ? W : hdsp_pkg::CFG_W;
    localparam logic [W-1:0]  REP_SAT = W'(MAX_CAPACITY + 1);
    localparam logic [CW-1:0] CAP_MAX = CW'(MAX_CAPACITY);

    typedef enum logic [2:0] {
        PH_NEXT    = 3'd0,
        PH_HEX     = 3'd1,
        PH_DOTS    = 3'd2,
        PH_PENDING = 3'd3,
        PH_COUNT   = 3'd4
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_byte,  n_byte;
    logic [W-1:0] r_rep, n_rep;
    logic [W-1:0] r_len, n_len;
    hdsp_pkg::t_err_code r_err, n_err;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      v = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    logic [7:0]    c;
    logic [4:0]    hx;
    logic [2:0]    dot_idx;
    logic [7:0]    dot_bit;
    logic [CW-1:0] cap_ext, cap_eff;
    logic [CW:0]   need;
    logic [MW-1:0] rep_ext, rep_mul;
    logic          try_en, start_en, emit;
    logic [W-1:0]  try_n;

    assign c       = i_req.character;
    assign hx      = hex_val(c);
    assign dot_idx = 3'(c - 8'h31);
    assign dot_bit = 8'd1 << dot_idx;
    assign cap_ext = CW'(i_cap);
    assign cap_eff = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;
    assign rep_ext = MW'(r_rep);
    // count * 10 + digit
    assign rep_mul = (rep_ext << 3) + (rep_ext << 1) + MW'(c[3:0]);

    always_comb begin
        n_phase  = r_phase;
        n_byte   = r_byte;
        n_rep    = r_rep;
        n_len    = r_len;
        n_err    = r_err;
        try_en   = 1'b0;
        try_n    = W'(1);
        start_en = 1'b0;
        emit     = 1'b0;
        need     = '0;

        if (i_req.mode) begin
            if (r_err == hdsp_pkg::ERR_NONE) begin
                unique case (r_phase)
                    PH_PENDING: try_en = 1'b1;
                    PH_COUNT: begin
                        if (r_rep == '0) n_err = hdsp_pkg::ERR_INCOMPLETE;
                        else begin
                            try_en = 1'b1;
                            try_n  = r_rep;
                        end
                    end
                    PH_HEX, PH_DOTS: n_err = hdsp_pkg::ERR_INCOMPLETE;
                    default: ;
                endcase
            end
        end else if (r_err == hdsp_pkg::ERR_NONE) begin
            unique case (r_phase)
                PH_HEX: begin
                    if (!hx[4]) n_err = hdsp_pkg::ERR_BAD_HEX;
                    else begin
                        n_byte  = r_byte | {4'd0, hx[3:0]};
                        n_phase = PH_PENDING;
                    end
                end
                PH_DOTS: begin
                    if (c == 8'h5d) n_phase = PH_PENDING;
                    else if (c < 8'h31 || c > 8'h38) n_err = hdsp_pkg::ERR_BAD_DOT;
                    else if ((r_byte & dot_bit) != 8'd0) n_err = hdsp_pkg::ERR_DUP_DOT;
                    else n_byte = r_byte | dot_bit;
                end
                PH_PENDING: begin
                    if (c == 8'h2a) begin
                        n_rep   = '0;
                        n_phase = PH_COUNT;
                    end else begin
                        try_en   = 1'b1;
                        n_phase  = PH_NEXT;
                        start_en = 1'b1;
                    end
                end
                PH_COUNT: begin
                    if (is_space(c)) begin
                        if (r_rep == '0) n_err = hdsp_pkg::ERR_NO_COUNT;
                        else begin
                            try_en  = 1'b1;
                            try_n   = r_rep;
                            n_phase = PH_NEXT;
                        end
                    end else if (c < 8'h30 || c > 8'h39) begin
                        n_err = hdsp_pkg::ERR_BAD_DIGIT;
                    end else if (c == 8'h30 && r_rep == '0) begin
                        n_err = hdsp_pkg::ERR_LEAD_ZERO;
                    end else begin
                        n_rep = (rep_mul > MW'(REP_SAT)) ? REP_SAT : W'(rep_mul);
                    end
                end
                default: begin
                    n_phase  = PH_NEXT;
                    start_en = 1'b1;
                end
            endcase
        end

        // capacity check; a failing record is dropped whole
        if (try_en) begin
            need = (CW+1)'(r_len) + (CW+1)'(try_n);
            if (need > (CW+1)'(cap_eff)) n_err = hdsp_pkg::ERR_TOO_SMALL;
            else begin
                emit  = 1'b1;
                n_len = W'(need);
            end
            n_byte = 8'd0;
            n_rep  = W'(1);
        end

        // start of a new item
        if (start_en && n_err == hdsp_pkg::ERR_NONE && !is_space(c)) begin
            if (c == 8'h5b) begin
                n_byte  = 8'd0;
                n_phase = PH_DOTS;
            end else if (!hx[4]) begin
                n_err = hdsp_pkg::ERR_BAD_HEX;
            end else begin
                n_byte  = {hx[3:0], 4'd0};
                n_phase = PH_HEX;
            end
        end

        o_res.emit         = emit;
        o_res.out_byte     = emit ? r_byte : 8'd0;
        o_res.repeat_res   = emit ? hdsp_pkg::FIELD_W'(try_n) : '0;
        o_res.done_res     = i_req.mode;
        o_res.error_code   = n_err;
        o_res.total_length = hdsp_pkg::FIELD_W'(n_len);
        o_res_valid        = i_req.mode | emit;

        // end marker restarts the parse
        if (i_req.mode) begin
            n_phase = PH_NEXT;
            n_byte  = 8'd0;
            n_rep   = W'(1);
            n_len   = '0;
            n_err   = hdsp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NEXT;
            r_byte  <= 8'd0;
            r_rep   <= W'(1);
            r_len   <= '0;
            r_err   <= hdsp_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_byte  <= n_byte;
            r_rep   <= n_rep;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hex_and_dot_byte_spec_parser_unit.sv =====
// Top level of the hex-and-dot byte spec parser: handshake, capacity register,
// result register. Depends on hdsp_pkg and hdsp_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req) carries one request per
//   character; mode 1 is the end-of-text marker. Output channel (o_out_valid /
//   i_out_ready / o_out_res) carries at most one record per request: a byte
//   record when an item completes, and always a done record on end of text.
//   The record shows on o_out_valid in the cycle after its request is accepted.
//   Throughput: 1 request per cycle unless the receiver stalls; parser state
//   steps per accepted request and the record lands in one output register.
//   Stall: o_in_ready = !o_out_valid | i_out_ready, so the output register
//   holds its record while the receiver stalls, and a new request is taken in
//   the same cycle the old record leaves.
//   Reset (i_rst_n low, synchronous): parser returns to the next-item state,
//   length and error cleared, buffer_capacity back to 4096, output empty.
//   Config: i_cfg_wr_en writes buffer_capacity; write only while idle.
//   Values above MAX_CAPACITY act as MAX_CAPACITY.
`default_nettype none

module hex_and_dot_byte_spec_parser_unit #(
    parameter int unsigned MAX_CAPACITY = hdsp_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [hdsp_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire hdsp_pkg::t_in_req          i_in_req,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output hdsp_pkg::t_out_res              o_out_res
);

    logic [hdsp_pkg::CFG_W-1:0] r_cap;
    logic                       r_out_valid;
    hdsp_pkg::t_out_res         r_out_res;
    hdsp_pkg::t_out_res         core_res;
    logic                       core_res_valid;
    logic                       in_acc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    hdsp_core #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_acc),
        .i_req       (i_in_req),
        .i_cap       (r_cap),
        .o_res       (core_res),
        .o_res_valid (core_res_valid)
    );

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= hdsp_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // result register; payload not reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && core_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && core_res_valid) begin
            r_out_res <= core_res;
        end
    end

    // a done record that carries a byte comes only from an error-free parse;
    // a mid-stream record may already show the error of the next item
    a_emit_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.emit && o_out_res.done_res
            |-> o_out_res.error_code == hdsp_pkg::ERR_NONE)
        else $error("record emitted with error code set");

    // non-done records are always byte records with a nonzero count
    a_mid_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.done_res |-> o_out_res.emit && o_out_res.repeat_res != '0)
        else $error("empty mid-stream record");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while result stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for hex_and_dot_byte_spec_parser_unit: directed and random
// byte specs are checked against an in-bench parser model. Depends on hdsp_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_CAP = hdsp_pkg::MAX_CAPACITY_DEF;

    // Parser phases of the in-bench model
    typedef enum logic [2:0] {
        PH_NEXT,
        PH_HEX,
        PH_DOTS,
        PH_PENDING,
        PH_COUNT
    } t_parse_phase;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [hdsp_pkg::CFG_W-1:0] i_cfg_wr_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    hdsp_pkg::t_in_req          i_in_req = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    hdsp_pkg::t_out_res         o_out_res;

    hex_and_dot_byte_spec_parser_unit #(
        .MAX_CAPACITY(MAX_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_res    (o_out_res)
    );

    // Idle enables for the request side and the record side
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    // Records the parser should still produce, oldest first
    hdsp_pkg::t_out_res pending_records[$];

    int unsigned fails = 0;
    int unsigned parsed_reqs = 0;   // requests not swallowed by a latched error
    int unsigned end_markers = 0;
    int unsigned records_seen = 0;

    // ------------------------------------------------------------------
    // Spec parser model: its own state and its own copy of the capacity
    // ------------------------------------------------------------------
    logic [hdsp_pkg::CFG_W-1:0] pr_cap;
    t_parse_phase               pr_phase;
    logic [7:0]                 pr_byte;
    int unsigned                pr_count;
    int unsigned                pr_length;
    hdsp_pkg::t_err_code        pr_err;
    hdsp_pkg::t_out_res         pr_rec;

    // Space, tab, LF, VT, FF, CR
    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function void clear_spec();
        pr_phase  = PH_NEXT;
        pr_byte   = '0;
        pr_count  = 1;
        pr_length = 0;
        pr_err    = hdsp_pkg::ERR_NONE;
    endfunction

    // Close the current byte with n copies; too long a spec latches an error
    // and nothing of that record comes out.
    function void close_byte(int unsigned n);
        int unsigned lim;
        lim = (pr_cap > MAX_CAP) ? MAX_CAP : pr_cap;
        if (pr_length + n > lim) begin
            pr_err = hdsp_pkg::ERR_TOO_SMALL;
        end else begin
            pr_rec.emit       = 1'b1;
            pr_rec.out_byte   = pr_byte;
            pr_rec.repeat_res = n[hdsp_pkg::FIELD_W-1:0];
            pr_length        += n;
        end
        pr_byte  = '0;
        pr_count = 1;
    endfunction

    function void open_item(logic [7:0] c);
        int d;
        d = hex_digit(c);
        if (is_blank(c)) return;
        if (c == "[") begin
            pr_byte  = '0;
            pr_phase = PH_DOTS;
        end else if (d < 0) begin
            pr_err = hdsp_pkg::ERR_BAD_HEX;
        end else begin
            pr_byte  = 8'(d << 4);
            pr_phase = PH_HEX;
        end
    endfunction

    // One request in; returns 1 with the record when the request yields one
    function bit parse_req(hdsp_pkg::t_in_req rq, output hdsp_pkg::t_out_res rec);
        int          d;
        int unsigned dot;
        logic [7:0]  c;
        c      = rq.character;
        pr_rec = '0;
        rec    = '0;
        if (rq.mode) begin
            if (pr_err == hdsp_pkg::ERR_NONE) begin
                case (pr_phase)
                    PH_PENDING: begin
                        close_byte(1);
                    end
                    PH_COUNT: begin
                        if (pr_count == 0) pr_err = hdsp_pkg::ERR_INCOMPLETE;
                        else close_byte(pr_count);
                    end
                    PH_HEX, PH_DOTS: begin
                        pr_err = hdsp_pkg::ERR_INCOMPLETE;
                    end
                    default: ;
                endcase
            end
            pr_rec.done_res     = 1'b1;
            pr_rec.error_code   = pr_err;
            pr_rec.total_length = pr_length[hdsp_pkg::FIELD_W-1:0];
            rec = pr_rec;
            clear_spec();
            return 1'b1;
        end
        if (pr_err != hdsp_pkg::ERR_NONE) return 1'b0;
        case (pr_phase)
            PH_HEX: begin
                d = hex_digit(c);
                if (d < 0) begin
                    pr_err = hdsp_pkg::ERR_BAD_HEX;
                end else begin
                    pr_byte  = pr_byte | 8'(d);
                    pr_phase = PH_PENDING;
                end
            end
            PH_DOTS: begin
                if (c == "]") begin
                    pr_phase = PH_PENDING;
                end else if (c < "1" || c > "8") begin
                    pr_err = hdsp_pkg::ERR_BAD_DOT;
                end else begin
                    dot = int'(c) - int'("1");
                    if (pr_byte[dot]) pr_err = hdsp_pkg::ERR_DUP_DOT;
                    else pr_byte[dot] = 1'b1;
                end
            end
            PH_PENDING: begin
                if (c == "*") begin
                    pr_count = 0;
                    pr_phase = PH_COUNT;
                end else begin
                    close_byte(1);
                    pr_phase = PH_NEXT;
                    if (pr_err == hdsp_pkg::ERR_NONE) open_item(c);
                end
            end
            PH_COUNT: begin
                if (is_blank(c)) begin
                    if (pr_count == 0) begin
                        pr_err = hdsp_pkg::ERR_NO_COUNT;
                    end else begin
                        close_byte(pr_count);
                        pr_phase = PH_NEXT;
                    end
                end else if (c < "0" || c > "9") begin
                    pr_err = hdsp_pkg::ERR_BAD_DIGIT;
                end else if (c == "0" && pr_count == 0) begin
                    pr_err = hdsp_pkg::ERR_LEAD_ZERO;
                end else begin
                    pr_count = pr_count * 10 + (int'(c) - int'("0"));
                    // saturate one above the limit so the capacity check trips
                    if (pr_count > MAX_CAP + 1) pr_count = MAX_CAP + 1;
                end
            end
            default: begin
                pr_phase = PH_NEXT;
                open_item(c);
            end
        endcase
        if (!pr_rec.emit) return 1'b0;
        pr_rec.error_code   = pr_err;
        pr_rec.total_length = pr_length[hdsp_pkg::FIELD_W-1:0];
        rec = pr_rec;
        return 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, monitor
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sampled at the rising edge: check the record leaving this cycle first,
    // then feed an accepted request to the model. A record shows in the cycle after
    // its request is accepted, so it is always queued by the time it is checked.
    always @(posedge i_clk) begin
        hdsp_pkg::t_out_res want;
        hdsp_pkg::t_out_res next_rec;
        if (!i_rst_n) begin
            pr_cap = hdsp_pkg::CAP_RESET;
            clear_spec();
            pending_records.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                records_seen++;
                if (pending_records.size() == 0) begin
                    $error("record with nothing expected: %h", o_out_res);
                    fails++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("emit", want.emit, o_out_res.emit);
                    check_field("out_byte", want.out_byte, o_out_res.out_byte);
                    check_field("repeat_res", want.repeat_res, o_out_res.repeat_res);
                    check_field("done_res", want.done_res, o_out_res.done_res);
                    check_field("error_code", want.error_code, o_out_res.error_code);
                    check_field("total_length", want.total_length,
                                o_out_res.total_length);
                end
            end
            if (i_cfg_wr_en) pr_cap = i_cfg_wr_data;
            if (i_in_valid && o_in_ready) begin
                if (i_in_req.mode || pr_err == hdsp_pkg::ERR_NONE) parsed_reqs++;
                if (i_in_req.mode) end_markers++;
                if (parse_req(i_in_req, next_rec)) pending_records.push_back(next_rec);
            end
        end
    end

    // Record side: draw a stall per record, then take it
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            n = rx_idle ? $urandom_range(0, 10) : 0;
            if (n != 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Valid stays up after acceptance until the next falling edge, where it
    // either carries the next request or drops for a gap.
    task automatic send_req(logic mode, logic [7:0] ch);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= '{mode: mode, character: ch};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_req(1'b0, s[i]);
    endtask

    // End marker; the character bits are don't-care, so randomize them
    task automatic send_end();
        send_req(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold off until every queued record has come out, then wait
    // out any request still in flight that yields nothing.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [hdsp_pkg::CFG_W-1:0] cap);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_blank();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    function automatic logic [7:0] pick_hex();
        int unsigned r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'("0" + r);
        if (r < 16) return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    // One random spec plus its end marker. Mostly well-formed: hex pairs and
    // dot lists with optional counts. Some specs carry a duplicate dot, a
    // leading zero, a missing count, a stray byte or an early end; a few are
    // raw noise.
    task automatic send_random_spec();
        logic [7:0]  txt[$];
        logic [7:0]  used;
        int unsigned n_items, seps, cnt, dot, val, r, cut;
        bit          had_count;
        string       num;
        had_count = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_items = $urandom_range(1, 6);
            for (int k = 0; k < n_items; k++) begin
                // no separator after a plain byte is legal and common enough
                if (k == 0) seps = $urandom_range(0, 2);
                else if (!had_count && $urandom_range(0, 3) == 0) seps = 0;
                else seps = $urandom_range(1, 2);
                repeat (seps) txt.push_back(pick_blank());
                if ($urandom_range(0, 1)) begin
                    txt.push_back(pick_hex());
                    txt.push_back(pick_hex());
                end else begin
                    used = '0;
                    txt.push_back("[");
                    cnt = $urandom_range(0, 8);
                    repeat (cnt) begin
                        dot = $urandom_range(0, 7);
                        if (!used[dot] || $urandom_range(0, 9) == 0) begin
                            txt.push_back(8'("1" + dot));
                            used[dot] = 1'b1;
                        end
                    end
                    txt.push_back("]");
                end
                had_count = ($urandom_range(0, 2) == 0);
                if (had_count) begin
                    txt.push_back("*");
                    r = $urandom_range(0, 19);
                    if (r == 0) val = 0;                               // missing count
                    else if (r == 2) val = $urandom_range(MAX_CAP + 1, 99999);
                    else if (r < 6) val = $urandom_range(1, MAX_CAP);
                    else val = $urandom_range(1, 20);
                    if (r == 1) txt.push_back("0");                   // leading zero
                    if (val != 0) begin
                        num = $sformatf("%0d", val);
                        for (int i = 0; i < num.len(); i++) txt.push_back(num[i]);
                    end
                end
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (r == 1) begin
                cut = $urandom_range(0, txt.size());
                while (txt.size() > cut) void'(txt.pop_back());
            end
        end
        foreach (txt[i]) send_req(1'b0, txt[i]);
        send_end();
    endtask

    task automatic run_random(int unsigned quota);
        int unsigned stop_at;
        stop_at = parsed_reqs + quota;
        while (parsed_reqs < stop_at) begin
            send_random_spec();
            // now and then let the parser drain completely
            if ($urandom_range(0, 7) == 0) wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hex in both cases, dots 1 and 8, a pending byte followed straight by
    // '[', a count ended by a blank, and a pending byte closed by the end.
    task automatic test_records();
        send_text("Fa[81]*12 e0");
        send_end();
        send_end();   // empty spec
    endtask

    // Each parse error on its own spec; characters after an error are ignored
    task automatic test_parse_errors();
        send_text("g1");
        send_end();
        send_req(1'b0, 8'h00);             // NUL is no hex digit
        send_end();
        send_text("[");
        send_req(1'b0, 8'hff);             // high byte where a dot belongs
        send_end();
        send_text("[11");
        send_end();
        send_text("00*0");
        send_end();
        send_text("00*\t");
        send_end();
        send_text("00*x");
        send_end();
        send_text("00*");                  // end right after the star
        send_end();
        send_text("a");                    // end inside a hex pair
        send_end();
        send_text("[1");                   // end inside a dot list
        send_end();
    endtask

    // Largest count that fits, count saturation, and the smallest capacity
    task automatic test_count_limits();
        send_text("09*4096");
        send_end();
        send_text("00*99999");
        send_end();
        set_capacity(13'd1);
        send_text("00 11");
        send_end();
        set_capacity(13'(MAX_CAP));
    endtask

    task automatic test_random_specs();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_random(150);
        // back to back on both sides
        set_capacity(13'($urandom_range(16, 200)));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(100);
        set_capacity(13'($urandom_range(1, MAX_CAP)));
        tx_idle = 1'b1;
        run_random(80);
        set_capacity(13'($urandom_range(1, 40)));
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        run_random(70);
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_records();
        test_parse_errors();
        test_count_limits();
        test_random_specs();

        wait_idle();
        $display("covered %0d parsed requests, %0d specs, %0d records checked;",
                 parsed_reqs, end_markers, records_seen);
        $display("capacities 1 to 4096, every error code, with and without idling");
        if (fails == 0 && pending_records.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
